// ===== rtl/rmq_pkg.sv =====
// shared widths, types and arithmetic steps for the rotation matrix to quaternion unit
`default_nettype none
package rmq_pkg;

  localparam int ELEM_W     = 16;
  localparam int CAND_W     = 19;
  localparam int PAIR_W     = 17;
  localparam int IN_W       = 144;
  localparam int OUT_W      = 72;
  localparam int SQ_IN_W    = 32;
  localparam int SQ_ROOT_W  = 16;
  localparam int SQ_REM_W   = 19;
  localparam int SQ_STAGES  = 8;
  localparam int DIV_V_W    = 15;
  localparam int DIV_NUM_W  = 29;
  localparam int DIV_Q_W    = 16;
  localparam int DIV_STAGES = 8;
  // s1, s2, sqrt stages, divider front stage plus stages, output register
  localparam int PIPE_DEPTH = 2 + SQ_STAGES + 1 + DIV_STAGES + 1;

  localparam logic signed [CAND_W-1:0] Q_ONE = 19'sd16384;

  typedef enum logic [1:0] {IDX_X, IDX_Y, IDX_Z, IDX_W} idx_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
  } sq_st_t;

  typedef struct packed {
    logic [DIV_V_W-1:0] rem;
    logic [DIV_Q_W-1:0] q;
  } dv_st_t;

  // one restoring square root step, two radicand bits in
  function automatic sq_st_t sqrt_step(sq_st_t s, logic [1:0] b);
    sq_st_t o;
    logic [SQ_REM_W-1:0] r;
    logic [SQ_REM_W-1:0] t;
    r = {s.rem[SQ_REM_W-3:0], b};
    t = {1'b0, s.root, 2'b01};
    if (r >= t) begin
      o.rem  = r - t;
      o.root = {s.root[SQ_ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {s.root[SQ_ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // one restoring division step, one dividend bit in
  function automatic dv_st_t div_step(dv_st_t s, logic b, logic [DIV_V_W-1:0] v);
    dv_st_t o;
    logic [DIV_V_W:0] r;
    logic [DIV_V_W:0] d;
    r = {s.rem, b};
    d = r - {1'b0, v};
    if (r >= {1'b0, v}) begin
      o.rem = d[DIV_V_W-1:0];
      o.q   = {s.q[DIV_Q_W-2:0], 1'b1};
    end else begin
      o.rem = r[DIV_V_W-1:0];
      o.q   = {s.q[DIV_Q_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // apply sign and saturate a quotient magnitude to q2.14
  function automatic logic [ELEM_W-1:0] sign_sat(logic [DIV_Q_W-1:0] q, logic neg);
    logic [DIV_Q_W:0] m;
    logic [DIV_Q_W:0] n;
    if (neg) begin
      m = (q > 16'd32768) ? 17'd32768 : {1'b0, q};
      n = -m;
      return n[ELEM_W-1:0];
    end
    return (q > 16'd32767) ? 16'd32767 : q;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rotation_matrix_to_quaternion_unit.sv =====
// top level: rotation matrix to quaternion, shepperd's method in q2.14
`default_nettype none
// Converts the upper-left 3x3 of a rotation matrix (signed q2.14, row-vector
// convention) to a quaternion (x, y, z, w) in signed q2.14 with saturation.
// The largest of the four candidates 1 +/- diagonal picks the component taken
// by square root (ties go to the lower index, reported as largest_index); the
// other three are off-diagonal sums over four times that component, rounded
// to nearest. Fully pipelined: one transaction per cycle in and out. Most of
// the depth lies in the 8-stage square root and in the divider stages after
// their front stage, each of these resolving two bits. The whole pipe advances
// whenever the output register is empty or being taken, so a stall on the
// result side holds every stage in place.
module rotation_matrix_to_quaternion_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // e00 e01 e02 e10 e11 e12 e20 e21 e22, 16 bits each, from bit 0 up
  input  wire logic [rmq_pkg::IN_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // qx qy qz qw (16 bits each), largest_index (2 bits), 6 zero bits
  output logic      [rmq_pkg::OUT_W-1:0]   out_tdata
);
  import rmq_pkg::*;

  logic en;
  logic [PIPE_DEPTH-1:0] vld_r;

  // pipe moves as one when the output slot is free or drained this cycle
  assign en         = out_tready | ~out_tvalid;
  assign in_tready  = en;
  assign out_tvalid = vld_r[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  // stage 1: candidates and off-diagonal pair sums and differences
  logic signed [ELEM_W-1:0] e [9];
  for (genvar i = 0; i < 9; i++) begin : g_unpack
    assign e[i] = in_tdata[i*ELEM_W +: ELEM_W];
  end

  logic signed [CAND_W-1:0] c00, c11, c22;
  logic signed [PAIR_W-1:0] e01, e02, e10, e12, e20, e21;
  assign c00 = CAND_W'(e[0]);
  assign c11 = CAND_W'(e[4]);
  assign c22 = CAND_W'(e[8]);
  assign e01 = PAIR_W'(e[1]);
  assign e02 = PAIR_W'(e[2]);
  assign e10 = PAIR_W'(e[3]);
  assign e12 = PAIR_W'(e[5]);
  assign e20 = PAIR_W'(e[6]);
  assign e21 = PAIR_W'(e[7]);

  logic signed [CAND_W-1:0] cand_r [4];
  logic signed [PAIR_W-1:0] p01a_r, p01d_r, p20a_r, p20d_r, p12a_r, p12d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cand_r[0] <= c00 - c11 - c22 + Q_ONE;
      cand_r[1] <= -c00 + c11 - c22 + Q_ONE;
      cand_r[2] <= -c00 - c11 + c22 + Q_ONE;
      cand_r[3] <= c00 + c11 + c22 + Q_ONE;
      p01a_r    <= e01 + e10;
      p01d_r    <= e01 - e10;
      p20a_r    <= e20 + e02;
      p20d_r    <= e20 - e02;
      p12a_r    <= e12 + e21;
      p12d_r    <= e12 - e21;
    end
  end

  // stage 2: pick the largest candidate, route the three pair terms
  idx_t                     best_nxt;
  logic signed [CAND_W-1:0] max_nxt;
  logic signed [PAIR_W-1:0] sa_nxt, sb_nxt, sc_nxt;

  always_comb begin
    best_nxt = IDX_X;
    max_nxt  = cand_r[0];
    if (cand_r[1] > max_nxt) begin
      best_nxt = IDX_Y;
      max_nxt  = cand_r[1];
    end
    if (cand_r[2] > max_nxt) begin
      best_nxt = IDX_Z;
      max_nxt  = cand_r[2];
    end
    if (cand_r[3] > max_nxt) begin
      best_nxt = IDX_W;
      max_nxt  = cand_r[3];
    end
    case (best_nxt)
      IDX_X: begin
        sa_nxt = p01a_r; sb_nxt = p20a_r; sc_nxt = p12d_r;
      end
      IDX_Y: begin
        sa_nxt = p01a_r; sb_nxt = p12a_r; sc_nxt = p20d_r;
      end
      IDX_Z: begin
        sa_nxt = p20a_r; sb_nxt = p12a_r; sc_nxt = p01d_r;
      end
      default: begin
        sa_nxt = p12d_r; sb_nxt = p20d_r; sc_nxt = p01d_r;
      end
    endcase
  end

  idx_t                     best2_r;
  logic [SQ_IN_W-1:0]       rad_r;
  logic signed [PAIR_W-1:0] sa_r, sb_r, sc_r;

  // largest candidate is always in [1.0, 7.0), so its low 17 bits are exact
  always_ff @(posedge clk) begin
    if (en) begin
      best2_r <= best_nxt;
      rad_r   <= {3'b000, max_nxt[CAND_W-3:0], 12'b0};
      sa_r    <= sa_nxt;
      sb_r    <= sb_nxt;
      sc_r    <= sc_nxt;
    end
  end

  // square root with side data delayed alongside
  logic [SQ_ROOT_W-1:0] root;

  rmq_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .n    (rad_r),
    .root (root)
  );

  idx_t                     best_sq_r [SQ_STAGES];
  logic signed [PAIR_W-1:0] sa_sq_r   [SQ_STAGES];
  logic signed [PAIR_W-1:0] sb_sq_r   [SQ_STAGES];
  logic signed [PAIR_W-1:0] sc_sq_r   [SQ_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      best_sq_r[0] <= best2_r;
      sa_sq_r[0]   <= sa_r;
      sb_sq_r[0]   <= sb_r;
      sc_sq_r[0]   <= sc_r;
      for (int k = 1; k < SQ_STAGES; k++) begin
        best_sq_r[k] <= best_sq_r[k-1];
        sa_sq_r[k]   <= sa_sq_r[k-1];
        sb_sq_r[k]   <= sb_sq_r[k-1];
        sc_sq_r[k]   <= sc_sq_r[k-1];
      end
    end
  end

  // three dividers share the root as divisor
  logic [DIV_V_W-1:0] v;
  logic [DIV_Q_W-1:0] qa, qb, qc;
  logic               na, nb, nc;

  assign v = root[DIV_V_W-1:0];

  rmq_div u_div_a (
    .clk (clk), .en (en), .s (sa_sq_r[SQ_STAGES-1]), .v (v), .q (qa), .neg (na)
  );
  rmq_div u_div_b (
    .clk (clk), .en (en), .s (sb_sq_r[SQ_STAGES-1]), .v (v), .q (qb), .neg (nb)
  );
  rmq_div u_div_c (
    .clk (clk), .en (en), .s (sc_sq_r[SQ_STAGES-1]), .v (v), .q (qc), .neg (nc)
  );

  localparam int DV_DLY = DIV_STAGES + 1;

  idx_t               best_dv_r [DV_DLY];
  logic [DIV_V_W-1:0] root_dv_r [DV_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      best_dv_r[0] <= best_sq_r[SQ_STAGES-1];
      root_dv_r[0] <= v;
      for (int k = 1; k < DV_DLY; k++) begin
        best_dv_r[k] <= best_dv_r[k-1];
        root_dv_r[k] <= root_dv_r[k-1];
      end
    end
  end

  // output register: sign, saturate and place the components
  logic [ELEM_W-1:0] ra, rb, rc, rr;
  logic [ELEM_W-1:0] qx_nxt, qy_nxt, qz_nxt, qw_nxt;
  idx_t              best_o;

  assign ra     = sign_sat(qa, na);
  assign rb     = sign_sat(qb, nb);
  assign rc     = sign_sat(qc, nc);
  assign rr     = {1'b0, root_dv_r[DV_DLY-1]};
  assign best_o = best_dv_r[DV_DLY-1];

  always_comb begin
    case (best_o)
      IDX_X: begin
        qx_nxt = rr; qy_nxt = ra; qz_nxt = rb; qw_nxt = rc;
      end
      IDX_Y: begin
        qx_nxt = ra; qy_nxt = rr; qz_nxt = rb; qw_nxt = rc;
      end
      IDX_Z: begin
        qx_nxt = ra; qy_nxt = rb; qz_nxt = rr; qw_nxt = rc;
      end
      default: begin
        qx_nxt = ra; qy_nxt = rb; qz_nxt = rc; qw_nxt = rr;
      end
    endcase
  end

  logic [OUT_W-1:0] out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= {6'b000000, best_o, qw_nxt, qz_nxt, qy_nxt, qx_nxt};
    end
  end

  assign out_tdata = out_r;

endmodule
`default_nettype wire

// ===== rtl/rmq_sqrt.sv =====
// pipelined integer square root, two result bits per stage
`default_nettype none
module rmq_sqrt (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [rmq_pkg::SQ_IN_W-1:0]    n,
  output logic      [rmq_pkg::SQ_ROOT_W-1:0]  root
);
  import rmq_pkg::*;

  logic [SQ_IN_W-1:0] n_r   [SQ_STAGES];
  sq_st_t             st_r  [SQ_STAGES];
  logic [SQ_IN_W-1:0] n_in  [SQ_STAGES];
  sq_st_t             st_in [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    sq_st_t a_nxt, b_nxt;
    if (k == 0) begin : g_first
      assign n_in[k]  = n;
      assign st_in[k] = '0;
    end else begin : g_next
      assign n_in[k]  = n_r[k-1];
      assign st_in[k] = st_r[k-1];
    end
    always_comb begin
      a_nxt = sqrt_step(st_in[k], n_in[k][SQ_IN_W-1 -: 2]);
      b_nxt = sqrt_step(a_nxt, n_in[k][SQ_IN_W-3 -: 2]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= b_nxt;
        n_r[k]  <= {n_in[k][SQ_IN_W-5:0], 4'b0000};
      end
    end
  end

  assign root = st_r[SQ_STAGES-1].root;

endmodule
`default_nettype wire

// ===== rtl/rmq_div.sv =====
// pipelined rounded quotient s*4096/v, two quotient bits per stage
`default_nettype none
module rmq_div (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [rmq_pkg::PAIR_W-1:0]   s,
  input  wire logic        [rmq_pkg::DIV_V_W-1:0]  v,
  output logic             [rmq_pkg::DIV_Q_W-1:0]  q,
  output logic                                     neg
);
  import rmq_pkg::*;

  logic [PAIR_W-1:0]    mag;
  logic [DIV_NUM_W-1:0] num_nxt;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_V_W-1:0]   v0_r;
  logic                 neg0_r;

  // magnitude plus half divisor for round to nearest
  assign mag     = s[PAIR_W-1] ? PAIR_W'(-s) : PAIR_W'(s);
  assign num_nxt = {mag, 12'b0} + {{(DIV_NUM_W-DIV_V_W+1){1'b0}}, v[DIV_V_W-1:1]};

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= num_nxt;
      v0_r   <= v;
      neg0_r <= s[PAIR_W-1];
    end
  end

  logic [DIV_Q_W-1:0] lo_r  [DIV_STAGES];
  dv_st_t             st_r  [DIV_STAGES];
  logic [DIV_V_W-1:0] v_r   [DIV_STAGES];
  logic               neg_r [DIV_STAGES];
  logic [DIV_Q_W-1:0] lo_in [DIV_STAGES];
  dv_st_t             st_in [DIV_STAGES];
  logic [DIV_V_W-1:0] v_in  [DIV_STAGES];
  logic               neg_in[DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    dv_st_t a_nxt, b_nxt;
    if (k == 0) begin : g_first
      assign lo_in[k]  = num_r[DIV_Q_W-1:0];
      assign st_in[k]  = '{rem: {2'b00, num_r[DIV_NUM_W-1:DIV_Q_W]}, q: '0};
      assign v_in[k]   = v0_r;
      assign neg_in[k] = neg0_r;
    end else begin : g_next
      assign lo_in[k]  = lo_r[k-1];
      assign st_in[k]  = st_r[k-1];
      assign v_in[k]   = v_r[k-1];
      assign neg_in[k] = neg_r[k-1];
    end
    always_comb begin
      a_nxt = div_step(st_in[k], lo_in[k][DIV_Q_W-1], v_in[k]);
      b_nxt = div_step(a_nxt, lo_in[k][DIV_Q_W-2], v_in[k]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k]  <= b_nxt;
        lo_r[k]  <= {lo_in[k][DIV_Q_W-3:0], 2'b00};
        v_r[k]   <= v_in[k];
        neg_r[k] <= neg_in[k];
      end
    end
  end

  assign q   = st_r[DIV_STAGES-1].q;
  assign neg = neg_r[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/rmq_checker.sv =====
// port-level checks for the rotation matrix to quaternion unit, with bind
`default_nettype none
module rmq_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic [rmq_pkg::IN_W-1:0]    in_tdata,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [rmq_pkg::OUT_W-1:0]   out_tdata
);
  import rmq_pkg::*;

  logic [ELEM_W-1:0] root_q;
  assign root_q = out_tdata[out_tdata[65:64]*ELEM_W +: ELEM_W];

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a held result keeps its transaction
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // the root component is in [0.5, 2.0)
  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> root_q[15] == 1'b0 && root_q >= 16'd8192)
    else $error("root component out of range");

  // pad bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[71:66] == 6'b000000)
    else $error("pad bits set");

  // with a free output side the unit takes input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  logic unused_in;
  assign unused_in = in_tvalid ^ (^in_tdata);

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
